// ===== src/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and codes for the TCP connection state machine
// Holds the state, event and status codes, the segment flag bits and the
// item structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package tcf_pkg;

  // Connection states
  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_SENT    = 4'd2,
    ST_SYN_RCVD    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_FIN_WAIT_1  = 4'd5,
    ST_FIN_WAIT_2  = 4'd6,
    ST_PEER_CLOSED = 4'd7,
    ST_CLOSING     = 4'd8,
    ST_FINAL_ACK   = 4'd9,
    ST_QUIET       = 4'd10
  } conn_state_t;

  // Event codes
  typedef enum logic [3:0] {
    ACT_ACTIVE_OPEN   = 4'd0,
    ACT_PASSIVE_OPEN  = 4'd1,
    ACT_CLOSE         = 4'd2,
    ACT_RX_SYN        = 4'd3,
    ACT_RX_SYNACK     = 4'd4,
    ACT_RX_ACK        = 4'd5,
    ACT_RX_FIN        = 4'd6,
    ACT_RX_RST        = 4'd7,
    ACT_OPEN_DEADLINE = 4'd8
  } action_t;

  // Status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_WRONG   = 2'd2,
    STAT_FATAL   = 2'd3
  } status_t;

  // Segment flag bits
  localparam logic [3:0] FL_NONE = 4'b0000;
  localparam logic [3:0] FL_SYN  = 4'b0001;
  localparam logic [3:0] FL_ACK  = 4'b0010;
  localparam logic [3:0] FL_FIN  = 4'b0100;
  localparam logic [3:0] FL_RST  = 4'b1000;

  // One input event
  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] peer_address;
    logic [31:0] local_address;
    logic [15:0] peer_port;
    logic [15:0] local_port;
    logic [31:0] seq_field;
    logic [31:0] ack_field;
    logic [31:0] initial_seq;
  } event_t;

  // One result
  typedef struct packed {
    logic        segment_valid;
    logic [3:0]  segment_flags;
    logic [31:0] segment_seq;
    logic [31:0] segment_ack;
    logic [31:0] peer_address;
    logic [31:0] local_address;
    logic [15:0] peer_port;
    logic [15:0] local_port;
    conn_state_t conn_state;
    status_t     status;
    logic        data_ack_pulse;
    logic        buffers_clear;
  } result_t;

endpackage

// ===== src/tcp_connection_fsm.sv =====
// ----------------------------------------------------------------------------
// tcp_connection_fsm: control state machine for one TCP connection
// Takes one event per item and returns one result per item: the new
// connection state, a status and at most one control segment.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event with its addresses,
//   ports, sequence and ack fields and the initial sequence number.
//   Output channel (out_valid/out_ready) carries exactly one result per
//   event, in order.
//   An accepted event waits in the input register; its result is then loaded
//   into the result register, which drives the output ports until the
//   receiver takes it.
//   Throughput: one event per cycle; the state lookup, the ack compare and
//   the register updates all fit in the single pass between the registers.
//   When the receiver stalls, the result register holds its item and the
//   input register can still take one more event; in_ready then drops.
//   Reset (rst, synchronous) returns the connection to CLOSED, clears all
//   stored numbers, addresses and ports, and empties both registers.
// ----------------------------------------------------------------------------
module tcp_connection_fsm
  import tcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic [31:0] peer_address,
  input  logic [31:0] local_address,
  input  logic [15:0] peer_port_in,
  input  logic [15:0] local_port_in,
  input  logic [31:0] seq_field,
  input  logic [31:0] ack_field,
  input  logic [31:0] initial_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        segment_valid,
  output logic [3:0]  segment_flags,
  output logic [31:0] segment_seq,
  output logic [31:0] segment_ack,
  output logic [31:0] peer_address_out,
  output logic [31:0] local_address_out,
  output logic [15:0] peer_port_out,
  output logic [15:0] local_port_out,
  output logic [3:0]  conn_state,
  output logic [1:0]  status,
  output logic        data_ack_pulse,
  output logic        buffers_clear
);

  event_t  in_item;
  event_t  stage_item;
  logic    stage_valid;
  logic    stage_fire;
  logic    can_load;
  result_t next_result;
  result_t out_item;

  // Gather the input fields
  always_comb begin
    in_item.action        = action;
    in_item.peer_address  = peer_address;
    in_item.local_address = local_address;
    in_item.peer_port     = peer_port_in;
    in_item.local_port    = local_port_in;
    in_item.seq_field     = seq_field;
    in_item.ack_field     = ack_field;
    in_item.initial_seq   = initial_seq;
  end

  tcf_input_stage u_input (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .downstream_ready (can_load),
    .stage_valid      (stage_valid),
    .stage_item       (stage_item),
    .stage_fire       (stage_fire)
  );

  tcf_event_logic u_logic (
    .clk    (clk),
    .rst    (rst),
    .update (stage_fire),
    .item   (stage_item),
    .result (next_result)
  );

  tcf_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (stage_valid),
    .load_item (next_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Spread the result onto the ports
  assign segment_valid     = out_item.segment_valid;
  assign segment_flags     = out_item.segment_flags;
  assign segment_seq       = out_item.segment_seq;
  assign segment_ack       = out_item.segment_ack;
  assign peer_address_out  = out_item.peer_address;
  assign local_address_out = out_item.local_address;
  assign peer_port_out     = out_item.peer_port;
  assign local_port_out    = out_item.local_port;
  assign conn_state        = out_item.conn_state;
  assign status            = out_item.status;
  assign data_ack_pulse    = out_item.data_ack_pulse;
  assign buffers_clear     = out_item.buffers_clear;

endmodule

// ===== src/tcf_input_stage.sv =====
// ----------------------------------------------------------------------------
// tcf_input_stage: input register for incoming events
// Captures one event per cycle while in_ready is high and hands it on when
// the result register can take the outcome.
// ----------------------------------------------------------------------------
module tcf_input_stage
  import tcf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  event_t in_item,
  input  logic   downstream_ready,
  output logic   stage_valid,
  output event_t stage_item,
  output logic   stage_fire
);

  logic   valid;
  event_t item;

  // Advance when the result register takes the held item
  assign stage_fire  = valid && downstream_ready;
  assign in_ready    = !valid || downstream_ready;
  assign stage_valid = valid;
  assign stage_item  = item;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== src/tcf_event_logic.sv =====
// ----------------------------------------------------------------------------
// tcf_event_logic: connection state and event decode
// Holds the connection registers and works out the new state and the
// result for one event in a single pass.
// ----------------------------------------------------------------------------
module tcf_event_logic
  import tcf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    update,
  input  event_t  item,
  output result_t result
);

  conn_state_t state, state_next;
  logic        open_pending, open_pending_next;
  logic [31:0] send_seq, send_seq_next;
  logic [31:0] send_acked, send_acked_next;
  logic [31:0] recv_ack, recv_ack_next;
  logic [31:0] peer_addr, peer_addr_next;
  logic [31:0] local_addr, local_addr_next;
  logic [15:0] peer_port, peer_port_next;
  logic [15:0] local_port, local_port_next;

  logic        seg;
  logic [3:0]  flags;
  status_t     stat;
  logic        pulse;
  logic        clear;
  logic [31:0] seq_plus_one;
  logic        synack_ok;

  assign seq_plus_one = item.seq_field + 32'd1;
  assign synack_ok    = (item.ack_field == send_seq + 32'd1);

  // Next state and stored numbers
  always_comb begin
    state_next        = state;
    open_pending_next = open_pending;
    send_seq_next     = send_seq;
    send_acked_next   = send_acked;
    recv_ack_next     = recv_ack;
    peer_addr_next    = peer_addr;
    local_addr_next   = local_addr;
    peer_port_next    = peer_port;
    local_port_next   = local_port;
    case (item.action)
      ACT_ACTIVE_OPEN: begin
        if (state == ST_CLOSED) begin
          peer_addr_next    = item.peer_address;
          local_addr_next   = item.local_address;
          peer_port_next    = item.peer_port;
          local_port_next   = item.local_port;
          send_seq_next     = item.initial_seq;
          send_acked_next   = item.initial_seq;
          state_next        = ST_SYN_SENT;
          open_pending_next = 1'b1;
        end
      end
      ACT_PASSIVE_OPEN: begin
        if (state == ST_CLOSED) begin
          state_next = ST_LISTEN;
        end
      end
      ACT_CLOSE: begin
        case (state)
          ST_LISTEN, ST_SYN_SENT:      state_next = ST_CLOSED;
          ST_SYN_RCVD, ST_ESTABLISHED: state_next = ST_FIN_WAIT_1;
          ST_PEER_CLOSED:              state_next = ST_FINAL_ACK;
          default:                     state_next = state;
        endcase
      end
      ACT_RX_SYN: begin
        peer_addr_next  = item.peer_address;
        local_addr_next = item.local_address;
        peer_port_next  = item.peer_port;
        local_port_next = item.local_port;
        if (state == ST_LISTEN) begin
          recv_ack_next   = seq_plus_one;
          send_seq_next   = item.initial_seq;
          send_acked_next = item.initial_seq;
          state_next      = ST_SYN_RCVD;
        end else if (state == ST_SYN_SENT) begin
          recv_ack_next = seq_plus_one;
          state_next    = ST_SYN_RCVD;
        end
      end
      ACT_RX_SYNACK: begin
        if (state == ST_SYN_SENT) begin
          send_acked_next = item.ack_field;
          if (synack_ok) begin
            recv_ack_next = seq_plus_one;
            state_next    = ST_ESTABLISHED;
          end
        end
      end
      ACT_RX_ACK: begin
        if (item.ack_field > send_acked) begin
          send_acked_next = item.ack_field;
        end
        case (state)
          ST_SYN_RCVD:   state_next = ST_ESTABLISHED;
          ST_FIN_WAIT_1: state_next = ST_FIN_WAIT_2;
          ST_CLOSING:    state_next = ST_QUIET;
          ST_FINAL_ACK:  state_next = ST_LISTEN;
          default:       state_next = state;
        endcase
      end
      ACT_RX_FIN: begin
        case (state)
          ST_ESTABLISHED: state_next = ST_PEER_CLOSED;
          ST_FIN_WAIT_1:  state_next = ST_CLOSING;
          ST_FIN_WAIT_2:  state_next = ST_QUIET;
          default:        state_next = state;
        endcase
      end
      ACT_RX_RST: begin
        if (state == ST_SYN_RCVD) begin
          state_next = ST_LISTEN;
        end
      end
      ACT_OPEN_DEADLINE: begin
        if (open_pending) begin
          open_pending_next = 1'b0;
          if (state != ST_ESTABLISHED) begin
            state_next = ST_CLOSED;
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Segment, status and pulses
  always_comb begin
    seg   = 1'b0;
    flags = FL_NONE;
    stat  = STAT_OK;
    pulse = 1'b0;
    clear = 1'b0;
    case (item.action)
      ACT_ACTIVE_OPEN: begin
        if (state == ST_CLOSED) begin
          seg   = 1'b1;
          flags = FL_SYN;
        end else begin
          stat = STAT_WRONG;
        end
      end
      ACT_PASSIVE_OPEN: begin
        if (state != ST_CLOSED) begin
          stat = STAT_WRONG;
        end
      end
      ACT_CLOSE: begin
        case (state)
          ST_LISTEN, ST_SYN_SENT: stat = STAT_OK;
          ST_SYN_RCVD, ST_ESTABLISHED, ST_PEER_CLOSED: begin
            seg   = 1'b1;
            flags = FL_FIN;
          end
          default: stat = STAT_FATAL;
        endcase
      end
      ACT_RX_SYN: begin
        if (state == ST_LISTEN) begin
          clear = 1'b1;
          seg   = 1'b1;
          flags = FL_SYN | FL_ACK;
        end else if (state == ST_SYN_SENT) begin
          seg   = 1'b1;
          flags = FL_SYN | FL_ACK;
        end else begin
          stat = STAT_WRONG;
        end
      end
      ACT_RX_SYNACK: begin
        if (state != ST_SYN_SENT) begin
          stat = STAT_WRONG;
        end else if (!synack_ok) begin
          stat = STAT_FATAL;
        end else begin
          seg   = 1'b1;
          flags = FL_ACK;
        end
      end
      ACT_RX_ACK: begin
        case (state)
          ST_SYN_RCVD, ST_FIN_WAIT_1, ST_CLOSING, ST_FINAL_ACK: stat = STAT_OK;
          ST_ESTABLISHED: pulse = 1'b1;
          default:        stat = STAT_WRONG;
        endcase
      end
      ACT_RX_FIN: begin
        case (state)
          ST_ESTABLISHED, ST_FIN_WAIT_1, ST_FIN_WAIT_2: begin
            seg   = 1'b1;
            flags = FL_ACK;
          end
          default: stat = STAT_WRONG;
        endcase
      end
      ACT_RX_RST: begin
        stat = (state == ST_SYN_RCVD) ? STAT_REFUSED : STAT_WRONG;
      end
      ACT_OPEN_DEADLINE: begin
        if (!open_pending) begin
          stat = STAT_WRONG;
        end else if (state == ST_ESTABLISHED) begin
          clear = 1'b1;
        end else begin
          seg   = 1'b1;
          flags = FL_RST;
          stat  = STAT_REFUSED;
        end
      end
      default: begin
        stat = STAT_WRONG;
      end
    endcase
  end

  // Pack the result
  always_comb begin
    result.segment_valid  = seg;
    result.segment_flags  = flags;
    result.segment_seq    = seg ? send_seq_next : 32'd0;
    result.segment_ack    = seg ? recv_ack_next : 32'd0;
    result.peer_address   = peer_addr_next;
    result.local_address  = local_addr_next;
    result.peer_port      = peer_port_next;
    result.local_port     = local_port_next;
    result.conn_state     = state_next;
    result.status         = stat;
    result.data_ack_pulse = pulse;
    result.buffers_clear  = clear;
  end

  // Commit the event
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLOSED;
      open_pending <= 1'b0;
      send_seq     <= 32'd0;
      send_acked   <= 32'd0;
      recv_ack     <= 32'd0;
      peer_addr    <= 32'd0;
      local_addr   <= 32'd0;
      peer_port    <= 16'd0;
      local_port   <= 16'd0;
    end else if (update) begin
      state        <= state_next;
      open_pending <= open_pending_next;
      send_seq     <= send_seq_next;
      send_acked   <= send_acked_next;
      recv_ack     <= recv_ack_next;
      peer_addr    <= peer_addr_next;
      local_addr   <= local_addr_next;
      peer_port    <= peer_port_next;
      local_port   <= local_port_next;
    end
  end

`ifndef SYNTHESIS
  // A fatal event leaves the connection state alone
  assert property (@(posedge clk) disable iff (rst)
    (update && result.status == STAT_FATAL) |-> (state_next == state))
    else $error("fatal event changed the connection state");

  // A refusal ends in CLOSED or LISTEN
  assert property (@(posedge clk) disable iff (rst)
    (update && result.status == STAT_REFUSED) |->
      (state_next == ST_CLOSED || state_next == ST_LISTEN))
    else $error("refused event left an unexpected state");

  // The quiet state is left only by reset or a pending open deadline
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_QUIET &&
     !(update && item.action == ACT_OPEN_DEADLINE && open_pending)) |=>
      (state == ST_QUIET))
    else $error("left the quiet state without reset or deadline");
`endif

endmodule

// ===== src/tcf_result_reg.sv =====
// ----------------------------------------------------------------------------
// tcf_result_reg: output register for results
// Holds one result until the receiver takes it; loads a new one in the
// same cycle the old one leaves.
// ----------------------------------------------------------------------------
module tcf_result_reg
  import tcf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_item,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  logic    valid;
  result_t item;

  assign can_load  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      item <= load_item;
    end
  end

endmodule
